// ----- src/piaw_pkg.sv -----
// Shared types and constants of the PI regulator with anti-windup.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package piaw_pkg;

   // Fraction bits of the fixed-point gains and values
   localparam int FRAC_BITS_DEFAULT = 8;

   // Field widths
   localparam int SAMPLE_W   = 18;
   localparam int GAIN_W     = 16;
   localparam int BIAS_W     = 19;
   localparam int ERR_W      = 19;
   localparam int INT_W      = 32;
   localparam int DRIVE_W    = 8;

   // Datapath widths
   localparam int ACC_W      = 64;
   localparam int INNER_W    = 48;
   localparam int MUL_A_W    = GAIN_W + 1;
   localparam int MUL_B_W    = 25;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int INT_HALF_W = INT_W / 2;
   localparam int INNER_LO_W = INNER_W / 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT  = 3'd0,
      CSR_PROP_GAIN = 3'd1,
      CSR_INT_GAIN  = 3'd2,
      CSR_UPPER     = 3'd3,
      CSR_LOWER     = 3'd4,
      CSR_BIAS      = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_I_LO,
      ST_MUL_I_HI,
      ST_ADD_I_HI,
      ST_INNER,
      ST_MUL_P_LO,
      ST_MUL_P_HI,
      ST_ADD_P_HI,
      ST_CLAMP
   } ctrl_state_type;

   // Operand fed to the shared multiplier
   typedef enum logic [1:0] {
      MUL_INT_LO,
      MUL_INT_HI,
      MUL_INNER_LO,
      MUL_INNER_HI
   } mul_src_type;

   // Weight of the product added into the accumulator
   typedef enum logic [1:0] {
      ACC_SFT_0,
      ACC_SFT_16,
      ACC_SFT_24
   } acc_sft_type;

   typedef struct packed {
      logic        load_sample;
      logic        update_int;
      logic        mul_en;
      mul_src_type mul_src;
      logic        acc_clr;
      logic        acc_add;
      acc_sft_type acc_sft;
      logic        load_inner;
      logic        load_result;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ----- src/piaw_if.sv -----
// Valid/ready channel interfaces for samples and results.
// Depends on piaw_pkg for the field widths.
`default_nettype none

interface piaw_req_if;
   import piaw_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] process_sample;

   modport source (output valid, output process_sample, input ready);
   modport sink   (input valid, input process_sample, output ready);
endinterface

interface piaw_rsp_if;
   import piaw_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] clamped_output;
   logic [DRIVE_W-1:0]  drive_value;

   modport source (output valid, output clamped_output, output drive_value, input ready);
   modport sink   (input valid, input clamped_output, input drive_value, output ready);
endinterface

`default_nettype wire

// ----- src/piaw_ctrl.sv -----
// Sequencer of the PI regulator: walks one sample through the datapath steps
// and owns the handshake flags. Depends on piaw_pkg.
`default_nettype none

module piaw_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output piaw_pkg::dp_cmd_type       cmd
);
   import piaw_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // State and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_src  = MUL_INT_LO;
      cmd.acc_sft  = ACC_SFT_0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.update_int = 1'b1;
            cmd.acc_clr    = 1'b1;
            state_in       = ST_MUL_I_LO;
         end
         ST_MUL_I_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_INT_LO;
            state_in    = ST_MUL_I_HI;
         end
         ST_MUL_I_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_INT_HI;
            cmd.acc_add = 1'b1;
            cmd.acc_sft = ACC_SFT_0;
            state_in    = ST_ADD_I_HI;
         end
         ST_ADD_I_HI: begin
            cmd.acc_add = 1'b1;
            cmd.acc_sft = ACC_SFT_16;
            state_in    = ST_INNER;
         end
         ST_INNER: begin
            cmd.load_inner = 1'b1;
            cmd.acc_clr    = 1'b1;
            state_in       = ST_MUL_P_LO;
         end
         ST_MUL_P_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_INNER_LO;
            state_in    = ST_MUL_P_HI;
         end
         ST_MUL_P_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_INNER_HI;
            cmd.acc_add = 1'b1;
            cmd.acc_sft = ACC_SFT_0;
            state_in    = ST_ADD_P_HI;
         end
         ST_ADD_P_HI: begin
            cmd.acc_add = 1'b1;
            cmd.acc_sft = ACC_SFT_24;
            state_in    = ST_CLAMP;
         end
         ST_CLAMP: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- src/piaw_dp.sv -----
// Datapath of the PI regulator: configuration registers, error and integral,
// shared 17x25 multiplier with a 64-bit accumulator, clamp and result register.
// Depends on piaw_pkg.
`default_nettype none

module piaw_dp #(
   parameter int FRAC_BITS = piaw_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire piaw_pkg::dp_cmd_type           cmd,
   input  wire logic [piaw_pkg::SAMPLE_W-1:0]  process_sample,
   input  wire logic                           csr_wr_en,
   input  wire logic [piaw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [piaw_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [piaw_pkg::SAMPLE_W-1:0]       clamped_output,
   output logic [piaw_pkg::DRIVE_W-1:0]        drive_value
);
   import piaw_pkg::*;

   localparam int DRIVE_SHIFT = FRAC_BITS + 2;

   // Configuration registers
   logic        [SAMPLE_W-1:0] setpoint_ff;
   logic        [GAIN_W-1:0]   prop_gain_ff;
   logic        [GAIN_W-1:0]   int_gain_ff;
   logic        [SAMPLE_W-1:0] upper_ff;
   logic        [SAMPLE_W-1:0] lower_ff;
   logic signed [BIAS_W-1:0]   bias_ff;

   // Loop state and work registers
   logic        [SAMPLE_W-1:0] sample_ff;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [INT_W-1:0]    int_ff, int_in;
   logic        [SAMPLE_W-1:0] prev_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [INNER_W-1:0]  inner_ff, inner_in;
   logic        [SAMPLE_W-1:0] clamped_ff, clamped_in;
   logic        [DRIVE_W-1:0]  drive_ff, drive_in;

   logic signed [INT_W:0]      int_sum;
   logic                       hold_hi, hold_lo;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [ACC_W-1:0]    prod_ext;
   logic signed [ACC_W-1:0]    acc_scaled;
   logic signed [ACC_W-1:0]    y_val;
   logic signed [ACC_W-1:0]    upper_ext, lower_ext;
   logic        [SAMPLE_W-1:0] drive_full;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= SAMPLE_W'(0);
         prop_gain_ff <= GAIN_W'(256);
         int_gain_ff  <= GAIN_W'(0);
         upper_ff     <= SAMPLE_W'(261888);
         lower_ff     <= SAMPLE_W'(0);
         bias_ff      <= BIAS_W'(0);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SETPOINT:  setpoint_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_PROP_GAIN: prop_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_INT_GAIN:  int_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_UPPER:     upper_ff     <= csr_wdata[SAMPLE_W-1:0];
            CSR_LOWER:     lower_ff     <= csr_wdata[SAMPLE_W-1:0];
            CSR_BIAS:      bias_ff      <= $signed(csr_wdata[BIAS_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Error and conditional integration on the fresh error of this sample
   always_comb begin
      err_in  = $signed({1'b0, setpoint_ff}) - $signed({1'b0, sample_ff});
      hold_hi = (prev_ff >= upper_ff) && !err_in[ERR_W-1] && (err_in != '0);
      hold_lo = (prev_ff <= lower_ff) && err_in[ERR_W-1];
      int_sum = $signed({int_ff[INT_W-1], int_ff})
              + $signed({{(INT_W+1-ERR_W){err_in[ERR_W-1]}}, err_in});
      int_in  = int_ff;
      if (!hold_hi && !hold_lo) begin
         if (int_sum[INT_W] != int_sum[INT_W-1]) begin
            // saturate at the signed 32-bit range
            int_in = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
         end else begin
            int_in = int_sum[INT_W-1:0];
         end
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.mul_src)
         MUL_INT_LO: begin
            mul_a = $signed({1'b0, int_gain_ff});
            mul_b = $signed({{(MUL_B_W-INT_HALF_W){1'b0}}, int_ff[INT_HALF_W-1:0]});
         end
         MUL_INT_HI: begin
            mul_a = $signed({1'b0, int_gain_ff});
            mul_b = $signed({{(MUL_B_W-INT_HALF_W){int_ff[INT_W-1]}},
                             int_ff[INT_W-1:INT_HALF_W]});
         end
         MUL_INNER_LO: begin
            mul_a = $signed({1'b0, prop_gain_ff});
            mul_b = $signed({{(MUL_B_W-INNER_LO_W){1'b0}}, inner_ff[INNER_LO_W-1:0]});
         end
         MUL_INNER_HI: begin
            mul_a = $signed({1'b0, prop_gain_ff});
            mul_b = $signed({{(MUL_B_W-(INNER_W-INNER_LO_W)){inner_ff[INNER_W-1]}},
                             inner_ff[INNER_W-1:INNER_LO_W]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // Weighted accumulate of the registered partial product
   always_comb begin
      prod_ext = $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
      acc_in   = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         case (cmd.acc_sft)
            ACC_SFT_0:  acc_in = acc_ff + prod_ext;
            ACC_SFT_16: acc_in = acc_ff + (prod_ext <<< INT_HALF_W);
            ACC_SFT_24: acc_in = acc_ff + (prod_ext <<< INNER_LO_W);
            default:    acc_in = acc_ff;
         endcase
      end
   end

   // Inner sum, output with bias and clamp
   always_comb begin
      acc_scaled = acc_ff >>> FRAC_BITS;
      inner_in   = $signed({{(INNER_W-ERR_W){err_ff[ERR_W-1]}}, err_ff})
                 + acc_scaled[INNER_W-1:0];
      y_val      = $signed({{(ACC_W-BIAS_W){bias_ff[BIAS_W-1]}}, bias_ff}) + acc_scaled;
      upper_ext  = $signed({{(ACC_W-SAMPLE_W){1'b0}}, upper_ff});
      lower_ext  = $signed({{(ACC_W-SAMPLE_W){1'b0}}, lower_ff});
      if (y_val > upper_ext) begin
         clamped_in = upper_ff;
      end else if (y_val < lower_ext) begin
         clamped_in = lower_ff;
      end else begin
         clamped_in = y_val[SAMPLE_W-1:0];
      end
      drive_full = clamped_in >> DRIVE_SHIFT;
      drive_in   = drive_full[DRIVE_W-1:0];
   end

   // Loop state: integral and last clamped output
   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff  <= '0;
         prev_ff <= '0;
      end else begin
         if (cmd.update_int) begin
            int_ff <= int_in;
         end
         if (cmd.load_result) begin
            prev_ff <= clamped_in;
         end
      end
   end

   // Work and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= process_sample;
      end
      if (cmd.update_int) begin
         err_ff <= err_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.load_inner) begin
         inner_ff <= inner_in;
      end
      if (cmd.load_result) begin
         clamped_ff <= clamped_in;
         drive_ff   <= drive_in;
      end
   end

   assign clamped_output = clamped_ff;
   assign drive_value    = drive_ff;

endmodule

`default_nettype wire

// ----- src/pi_controller_antiwindup_unit.sv -----
// PI regulator with conditional-integration anti-windup.
//
// Channels: req_bus carries one measured process_sample per beat; rsp_bus returns
// one beat per sample with clamped_output and drive_value (the clamped value
// shifted right by FRAC_BITS+2). Both use valid/ready; a beat moves on a rising
// edge with valid and ready high. Gains, setpoint, limits and bias go in through
// csr_wr_en/csr_index/csr_wdata; the user must write them only while idle (unchecked).
//
// A sample walks through nine sequencer steps that share one 17x25 multiplier:
// two partial products for the integral term, two for the proportional term,
// then the clamp. A new sample is taken only after the previous one has loaded
// its result and the sequencer is back in idle.
// Reset: synchronous, clears the integral and the previous output, and loads
// the register defaults (Kp = 1.0, upper limit 261888, all else zero).
// Stall: a finished result sits in the output register; the next sample is
// taken meanwhile, and its final step waits until the result is taken.
// Depends on piaw_pkg, piaw_if, piaw_ctrl and piaw_dp.
`default_nettype none

module pi_controller_antiwindup_unit #(
   parameter int FRAC_BITS = piaw_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   piaw_req_if.sink                             req_bus,
   piaw_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_wr_en,
   input  wire logic [piaw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [piaw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import piaw_pkg::*;

   localparam int DRIVE_SHIFT = FRAC_BITS + 2;

   dp_cmd_type          cmd;
   logic                req_ready;
   logic                rsp_valid;
   logic [SAMPLE_W-1:0] clamped_output;
   logic [DRIVE_W-1:0]  drive_value;
   logic [SAMPLE_W-1:0] drive_check;

   piaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   piaw_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .process_sample (req_bus.process_sample),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .clamped_output (clamped_output),
      .drive_value    (drive_value)
   );

   // Drive the channel ports
   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.clamped_output = clamped_output;
   assign rsp_bus.drive_value    = drive_value;

   assign drive_check = clamped_output >> DRIVE_SHIFT;

   // A taken sample makes the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("sample taken while a sample is in progress");

   // With the output register empty, a taken sample's result arrives with no stall
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && !rsp_bus.valid |-> ##10 rsp_bus.valid)
      else $error("result missing after sample beat");

   // Drive value follows the clamped output
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.drive_value == drive_check[DRIVE_W-1:0])
      else $error("drive value does not match clamped output");

endmodule

`default_nettype wire

// ----- test/piaw_scoreboard_pkg.sv -----
// Scoreboard for the PI regulator testbench: a cycle-free predictor of the
// regulator and the queue of outputs it expects. Depends on piaw_pkg.
package piaw_tb_pkg;
   import piaw_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int DRIVE_SHIFT = FRAC + 2;
   localparam int KP_RESET    = 256;
   localparam int UPPER_RESET = 261888;
   localparam longint INTEGRAL_MAX = 64'sd2147483647;
   localparam longint INTEGRAL_MIN = -64'sd2147483648;

   // One set of regulator registers
   typedef struct {
      logic [SAMPLE_W-1:0]        setpoint;
      logic [GAIN_W-1:0]          kp;
      logic [GAIN_W-1:0]          ki;
      logic [SAMPLE_W-1:0]        upper;
      logic [SAMPLE_W-1:0]        lower;
      logic signed [BIAS_W-1:0]   bias;
   } piaw_settings_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] clamped;
      logic [DRIVE_W-1:0]  drive;
   } piaw_result_type;

   class piaw_output_scoreboard;
      logic [SAMPLE_W-1:0]      setpoint;
      logic [GAIN_W-1:0]        kp;
      logic [GAIN_W-1:0]        ki;
      logic [SAMPLE_W-1:0]      upper;
      logic [SAMPLE_W-1:0]      lower;
      logic signed [BIAS_W-1:0] bias;
      logic signed [INT_W-1:0]  integral;
      logic [SAMPLE_W-1:0]      last_output;
      piaw_result_type          expected_outputs[$];
      int                       mismatches;

      function new();
         setpoint    = '0;
         kp          = GAIN_W'(KP_RESET);
         ki          = '0;
         upper       = SAMPLE_W'(UPPER_RESET);
         lower       = '0;
         bias        = '0;
         integral    = '0;
         last_output = '0;
         mismatches  = 0;
      endfunction

      // Mirror a register write; unknown indexes are dropped
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (csr_index_type'(idx))
            CSR_SETPOINT:  setpoint = data[SAMPLE_W-1:0];
            CSR_PROP_GAIN: kp       = data[GAIN_W-1:0];
            CSR_INT_GAIN:  ki       = data[GAIN_W-1:0];
            CSR_UPPER:     upper    = data[SAMPLE_W-1:0];
            CSR_LOWER:     lower    = data[SAMPLE_W-1:0];
            CSR_BIAS:      bias     = data[BIAS_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the regulator by one accepted sample and queue its output
      function void note_sample(logic [SAMPLE_W-1:0] sample);
         longint          err;
         longint          sum;
         longint          inner;
         longint          y;
         bit              hold_high;
         bit              hold_low;
         piaw_result_type r;
         err = longint'(setpoint) - longint'(sample);

         // conditional integration: freeze while pushing further into a limit
         hold_high = (last_output >= upper) && (err > 0);
         hold_low  = (last_output <= lower) && (err < 0);
         if (!hold_high && !hold_low) begin
            sum = longint'(integral) + err;
            if (sum > INTEGRAL_MAX) begin
               sum = INTEGRAL_MAX;
            end else if (sum < INTEGRAL_MIN) begin
               sum = INTEGRAL_MIN;
            end
            integral = sum[INT_W-1:0];
         end

         inner = err + ((longint'(ki) * longint'(integral)) >>> FRAC);
         y = longint'(bias) + ((longint'(kp) * inner) >>> FRAC);

         // when the limits are crossed, values above upper take upper and all others take lower
         if (y > longint'(upper)) begin
            y = longint'(upper);
         end else if (y < longint'(lower)) begin
            y = longint'(lower);
         end

         r.clamped   = y[SAMPLE_W-1:0];
         r.drive     = DRIVE_W'(r.clamped >> DRIVE_SHIFT);
         last_output = r.clamped;
         expected_outputs.push_back(r);
      endfunction

      // Compare one output beat against the oldest expected output
      function void check_output(logic [SAMPLE_W-1:0] clamped, logic [DRIVE_W-1:0] drive,
                                 time stamp);
         piaw_result_type exp_r;
         if (expected_outputs.size() == 0) begin
            $display("%0d ns: output beat with none expected: clamped_output %0d, drive_value %0d",
                     stamp, clamped, drive);
            mismatches++;
            return;
         end
         exp_r = expected_outputs.pop_front();
         if (clamped !== exp_r.clamped) begin
            $display("%0d ns: clamped_output expected %0d, got %0d",
                     stamp, exp_r.clamped, clamped);
            mismatches++;
         end
         if (drive !== exp_r.drive) begin
            $display("%0d ns: drive_value expected %0d, got %0d",
                     stamp, exp_r.drive, drive);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_outputs.size();
      endfunction

      // Count outputs that never came back
      function void close_out();
         if (expected_outputs.size() != 0) begin
            $display("%0d outputs still expected at end of run", expected_outputs.size());
            mismatches += expected_outputs.size();
         end
      endfunction

      function int failures();
         return mismatches;
      endfunction
   endclass

endpackage

// ----- test/pi_controller_antiwindup_unit_tb.sv -----
// Testbench top for pi_controller_antiwindup_unit: drives samples and register
// writes, throttles both channels and checks every output beat.
// Depends on piaw_pkg, piaw_if, piaw_tb_pkg and the regulator RTL.
module pi_controller_antiwindup_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import piaw_pkg::*;
   import piaw_tb_pkg::*;

   localparam int CLK_PERIOD          = 8;
   localparam int RESET_CYCLES        = 9;
   localparam int IDLE_PCT            = 14;
   localparam int SETTLE_CYCLES       = 20;
   localparam int TAIL_CYCLES         = 30;
   localparam int WATCHDOG_LIMIT      = 5000;
   localparam int BACKPRESSURE_AT     = 200;
   localparam int BACKPRESSURE_CYCLES = 300;
   localparam int RANDOM_PHASES       = 8;
   localparam int PHASE_ITEMS         = 145;
   localparam int SHORT_PHASE_ITEMS   = 25;
   localparam int STEADY_PHASE        = 3;
   localparam int WINDUP_UP_ITEMS     = 60;
   localparam int WINDUP_DOWN_ITEMS   = 60;
   localparam int WINDUP_SPAN         = 16;
   localparam int WINDUP_BIAS         = 100000;
   localparam int SAMPLE_MAX          = (1 << SAMPLE_W) - 1;
   localparam int GAIN_MAX            = (1 << GAIN_W) - 1;
   localparam int BIAS_MAX            = (1 << (BIAS_W - 1)) - 1;
   localparam int BIAS_MIN            = -(1 << (BIAS_W - 1));
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    steady;

   piaw_req_if req_ch();
   piaw_rsp_if rsp_ch();

   piaw_output_scoreboard sb = new();

   pi_controller_antiwindup_unit #(.FRAC_BITS(FRAC_BITS_DEFAULT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Record sample beats and check output beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_output(rsp_ch.clamped_output, rsp_ch.drive_value, $time);
         if (req_ch.valid && req_ch.ready)
            sb.note_sample(req_ch.process_sample);
      end
   end

   // Output side: random stalls plus one long hold-off to fill the block
   initial begin : receiver
      int delivered;
      int hold_left;
      bit pressed;
      delivered = 0;
      hold_left = 0;
      pressed   = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            delivered++;
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!pressed && delivered >= BACKPRESSURE_AT) begin
            pressed = 1'b1;
            hold_left = BACKPRESSURE_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // End the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Offer one sample, with random idle cycles ahead of it; hold until taken
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.process_sample <= sample;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Drop valid and wait until every expected output is back and the block is quiet
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // Program all registers; junk goes into the unused upper data bits when noisy
   task automatic apply_settings(input piaw_settings_type s, input bit noisy, input bit spare);
      logic [CSR_DATA_W-1:0] junk;
      wait_idle();
      junk = noisy ? CSR_DATA_W'($urandom) : '0;
      write_reg(CSR_SETPOINT,  {junk[CSR_DATA_W-1:SAMPLE_W], s.setpoint});
      write_reg(CSR_PROP_GAIN, {junk[CSR_DATA_W-1:GAIN_W], s.kp});
      write_reg(CSR_INT_GAIN,  {~junk[CSR_DATA_W-1:GAIN_W], s.ki});
      write_reg(CSR_UPPER,     {~junk[CSR_DATA_W-1:SAMPLE_W], s.upper});
      write_reg(CSR_LOWER,     {junk[CSR_DATA_W-1:SAMPLE_W], s.lower});
      write_reg(CSR_BIAS,      s.bias);
      if (spare) begin
         write_reg(CSR_SPARE_A, CSR_DATA_W'($urandom));
         write_reg(CSR_SPARE_B, CSR_DATA_W'($urandom));
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic piaw_settings_type make_settings(input int sp, input int kp, input int ki,
                                                       input int up, input int lo,
                                                       input int bias);
      piaw_settings_type s;
      s.setpoint = SAMPLE_W'(sp);
      s.kp       = GAIN_W'(kp);
      s.ki       = GAIN_W'(ki);
      s.upper    = SAMPLE_W'(up);
      s.lower    = SAMPLE_W'(lo);
      s.bias     = BIAS_W'(bias);
      return s;
   endfunction

   // Mostly modest gains, sometimes full-range; wide limits or random ones, sometimes crossed
   function automatic piaw_settings_type random_settings();
      piaw_settings_type   s;
      logic [SAMPLE_W-1:0] a;
      logic [SAMPLE_W-1:0] b;
      s.setpoint = SAMPLE_W'($urandom);
      s.kp = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 1023));
      s.ki = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(0, 63));
      if ($urandom_range(0, 1) == 0) begin
         s.upper = SAMPLE_W'(SAMPLE_MAX - $urandom_range(0, 4095));
         s.lower = SAMPLE_W'($urandom_range(0, 4095));
      end else begin
         a = SAMPLE_W'($urandom);
         b = SAMPLE_W'($urandom);
         if ((a > b) == ($urandom_range(0, 4) != 0)) begin
            s.upper = a;
            s.lower = b;
         end else begin
            s.upper = b;
            s.lower = a;
         end
      end
      s.bias = BIAS_W'($urandom);
      return s;
   endfunction

   // Most samples near the setpoint so the output moves, the rest anywhere
   function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] center);
      int v;
      if ($urandom_range(0, 9) < 6) begin
         v = int'(center) + int'($urandom_range(0, 4095)) - 2048;
         if (v < 0)
            v = 0;
         else if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
         return SAMPLE_W'(v);
      end
      return SAMPLE_W'($urandom);
   endfunction

   task automatic run_random_phase(input int items, input bit spare);
      piaw_settings_type s;
      s = random_settings();
      apply_settings(s, 1'b1, spare);
      repeat (items) send_sample(pick_sample(s.setpoint));
   endtask

   initial begin : stimulus
      int p;
      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_SETPOINT;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.process_sample <= '0;
      steady                <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: sample extremes and alternating bit patterns
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(18'h2AAAA);
      send_sample(18'h15555);

      // drive into the upper limit, then push further with positive error
      apply_settings(make_settings(SAMPLE_MAX, GAIN_MAX, GAIN_MAX, SAMPLE_MAX, 0, BIAS_MAX),
                     1'b0, 1'b1);
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(SAMPLE_W'(100));

      // drive into the lower limit, then push further with negative error
      apply_settings(make_settings(0, GAIN_MAX, GAIN_MAX, SAMPLE_MAX, 0, BIAS_MIN),
                     1'b0, 1'b0);
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(5));

      // lower limit above upper limit
      apply_settings(make_settings(131072, 256, 0, 1000, 200000, 0), 1'b0, 1'b0);
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(SAMPLE_W'(131072));
      send_sample(SAMPLE_W'(130500));

      // zero and unit-step error with a large integral gain
      apply_settings(make_settings(65536, 1, GAIN_MAX, SAMPLE_MAX, 0, 0), 1'b0, 1'b0);
      send_sample(SAMPLE_W'(65536));
      send_sample(SAMPLE_W'(65535));
      send_sample(SAMPLE_W'(65537));

      // random settings; one phase runs with no idling on either side
      for (p = 0; p < RANDOM_PHASES; p++) begin
         steady <= (p == STEADY_PHASE);
         run_random_phase(PHASE_ITEMS, p == 0);
      end
      steady <= 1'b0;

      // grow the integral with a large positive error, small gains keep it visible
      apply_settings(make_settings(SAMPLE_MAX, 1, 1, SAMPLE_MAX, 0, WINDUP_BIAS), 1'b0, 1'b0);
      repeat (WINDUP_UP_ITEMS) send_sample(SAMPLE_W'($urandom_range(0, WINDUP_SPAN - 1)));
      run_random_phase(SHORT_PHASE_ITEMS, 1'b0);

      // and pull it back down with a large negative error
      apply_settings(make_settings(0, 1, 1, SAMPLE_MAX, 0, WINDUP_BIAS), 1'b0, 1'b0);
      repeat (WINDUP_DOWN_ITEMS)
         send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX - WINDUP_SPAN + 1, SAMPLE_MAX)));
      run_random_phase(SHORT_PHASE_ITEMS, 1'b0);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.failures() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
